### hw/rtl/cpr_pkg.sv
`timescale 1ns / 1ps

package cpr_pkg;

	// Default geometry
	localparam int FRAMES_DEF    = 4;
	localparam int PAGE_BITS_DEF = 16;

	// Fixed field widths
	localparam int PAGE_W  = 16;
	localparam int INDEX_W = 2;
	localparam int FAULT_W = 32;

	localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

endpackage

### hw/rtl/cpr_page_mem.sv
`timescale 1ns / 1ps

// Page number store: one write port, one registered read port.
module cpr_page_mem #(
	parameter int DEPTH = cpr_pkg::FRAMES_DEF,
	parameter int WIDTH = cpr_pkg::PAGE_BITS_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hw/rtl/clock_page_replacement.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake                Payload
// in       in   in_valid / in_ready      page_number
// out      out  out_valid / out_ready    hit, frame_index, fault_total
//
// One item at a time. Lookup reads one frame per cycle from the page store
// through a single comparator. After a miss, the hand steps one frame per
// cycle, clearing set reference bits, until it reaches a clear one, and
// the victim is written there.
// Reset (arst_n low) empties every frame, parks the hand at frame 0 and
// clears the fault count. No clearing pass: valid bits gate the store.
// A result waits in the output register; if it is still held when the
// next one is ready, the sequencer stalls on that final step.
module clock_page_replacement #(
	parameter int FRAMES    = cpr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [cpr_pkg::PAGE_W-1:0]   page_number,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic [cpr_pkg::INDEX_W-1:0]  frame_index,
	output logic [cpr_pkg::FAULT_W-1:0]  fault_total
);

	import cpr_pkg::*;

	localparam int IW = $clog2(FRAMES);          // frame index width
	localparam int CW = $clog2(FRAMES + 1);      // lookup issue counter width
	localparam logic [IW-1:0] LAST_FRAME = IW'(FRAMES - 1);
	localparam logic [CW-1:0] ISSUE_END  = CW'(FRAMES);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LOOK  = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;

	logic [1:0]           state_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [CW-1:0]        issue_q;
	logic                 chk_vld_s1;
	logic [IW-1:0]        chk_idx_s1;
	logic [PAGE_BITS-1:0] rd_page_s1;
	logic [FRAMES-1:0]    frame_valid_q;
	logic [FRAMES-1:0]    frame_ref_q;
	logic [IW-1:0]        hand_q;
	logic [FAULT_W-1:0]   fault_q;

	logic                 out_valid_q;
	logic                 hit_q;
	logic [INDEX_W-1:0]   frame_index_q;
	logic [FAULT_W-1:0]   fault_total_q;

	// Input page masked to PAGE_BITS (zero-extended when wider)
	logic [PAGE_BITS+PAGE_W-1:0] page_ext;
	logic [PAGE_BITS-1:0]        page_in;

	logic               out_free;
	logic               issue_more;
	logic               is_match;
	logic               look_miss;
	logic               victim;
	logic               finish_hit;
	logic               finish_miss;
	logic               rd_en;
	logic [IW-1:0]      hand_next;
	logic [FAULT_W-1:0] fault_next;
	logic [IW+1:0]      chk_idx_ext;
	logic [IW+1:0]      hand_ext;

	assign page_ext = {{PAGE_BITS{1'b0}}, page_number};
	assign page_in  = page_ext[PAGE_BITS-1:0];

	assign in_ready   = (state_q == ST_IDLE);
	assign out_free   = !out_valid_q || out_ready;
	assign issue_more = (issue_q != ISSUE_END);

	// Shared comparator on the registered store read
	assign is_match = (state_q == ST_LOOK) && chk_vld_s1 &&
		frame_valid_q[chk_idx_s1] && (rd_page_s1 == page_q);
	// Every frame checked, none matched
	assign look_miss = (state_q == ST_LOOK) && !chk_vld_s1 && !issue_more;
	// Hand sits on a frame whose reference bit is clear
	assign victim = (state_q == ST_SWEEP) && !frame_ref_q[hand_q];

	assign finish_hit  = is_match && out_free;
	assign finish_miss = victim && out_free;

	assign rd_en     = (state_q == ST_LOOK) && issue_more && !is_match;
	assign hand_next = (hand_q == LAST_FRAME) ? '0 : hand_q + 1'b1;
	assign fault_next = (fault_q == FAULT_MAX) ? fault_q : fault_q + 1'b1;

	assign chk_idx_ext = {2'b00, chk_idx_s1};
	assign hand_ext    = {2'b00, hand_q};

	cpr_page_mem #(
		.DEPTH (FRAMES),
		.WIDTH (PAGE_BITS)
	) u_page_mem (
		.clk     (clk),
		.wr_en   (finish_miss),
		.wr_addr (hand_q),
		.wr_data (page_q),
		.rd_en   (rd_en),
		.rd_addr (issue_q[IW-1:0]),
		.rd_data (rd_page_s1)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			issue_q       <= '0;
			chk_vld_s1    <= 1'b0;
			frame_valid_q <= '0;
			frame_ref_q   <= '0;
			hand_q        <= '0;
			fault_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// result register: load on finish, drop once taken
			if (finish_hit || finish_miss) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						issue_q    <= '0;
						chk_vld_s1 <= 1'b0;
						state_q    <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (is_match) begin
						// hold until the output register frees up
						if (out_free) begin
							frame_ref_q[chk_idx_s1] <= 1'b1;
							state_q                 <= ST_IDLE;
						end
					end else if (look_miss) begin
						state_q <= ST_SWEEP;
					end else begin
						chk_vld_s1 <= issue_more;
						if (issue_more) begin
							issue_q <= issue_q + 1'b1;
						end
					end
				end
				ST_SWEEP: begin
					if (victim) begin
						if (out_free) begin
							frame_valid_q[hand_q] <= 1'b1;
							frame_ref_q[hand_q]   <= 1'b1;
							hand_q                <= hand_next;
							fault_q               <= fault_next;
							state_q               <= ST_IDLE;
						end
					end else begin
						// second chance: clear and move on
						frame_ref_q[hand_q] <= 1'b0;
						hand_q              <= hand_next;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			page_q <= page_in;
		end
		if (rd_en) begin
			chk_idx_s1 <= issue_q[IW-1:0];
		end
		if (finish_hit) begin
			hit_q         <= 1'b1;
			frame_index_q <= chk_idx_ext[INDEX_W-1:0];
			fault_total_q <= fault_q;
		end else if (finish_miss) begin
			hit_q         <= 1'b0;
			frame_index_q <= hand_ext[INDEX_W-1:0];
			fault_total_q <= fault_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign frame_index = frame_index_q;
	assign fault_total = fault_total_q;

	// A result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(finish_hit || finish_miss) |-> out_free)
		else $error("result register overwritten");

	// A hit leaves its frame referenced
	a_hit_ref: assert property (@(posedge clk) disable iff (!arst_n)
		finish_hit |=> frame_ref_q[$past(chk_idx_s1)])
		else $error("hit frame not referenced");

	// A fault leaves the victim valid and referenced
	a_victim_fill: assert property (@(posedge clk) disable iff (!arst_n)
		finish_miss |=> frame_valid_q[$past(hand_q)] && frame_ref_q[$past(hand_q)])
		else $error("victim frame not filled");

	// Fault count steps by one per fault, or stays saturated
	a_fault_step: assert property (@(posedge clk) disable iff (!arst_n)
		finish_miss |=> (fault_q == $past(fault_q) + 1'b1) ||
			($past(fault_q) == FAULT_MAX && fault_q == FAULT_MAX))
		else $error("fault count step wrong");

endmodule

### verif/clock_page_replacement_test.sv
`timescale 1ns / 1ps

// Page-reference tracker: a software copy of the frame table. It predicts the
// hit/fault, frame and fault total for every accepted page and compares them
// in order against what the block returns.
class page_ref_book;

	typedef struct {
		logic                          hit;
		logic [cpr_pkg::INDEX_W-1:0]   frame;
		logic [cpr_pkg::FAULT_W-1:0]   total;
	} outcome_t;

	logic [cpr_pkg::PAGE_W-1:0]  page_of [cpr_pkg::FRAMES_DEF];
	bit                          in_use  [cpr_pkg::FRAMES_DEF];
	bit                          recent  [cpr_pkg::FRAMES_DEF];
	int                          hand;
	logic [cpr_pkg::FAULT_W-1:0] faults;
	outcome_t                    due[$];
	int                          errors;

	function new();
		for (int i = 0; i < cpr_pkg::FRAMES_DEF; i++) begin
			page_of[i] = '0;
			in_use[i]  = 0;
			recent[i]  = 0;
		end
		hand   = 0;
		faults = '0;
		errors = 0;
	endfunction

	// Accepted page: update the frame table and queue the outcome.
	function void note_page(logic [cpr_pkg::PAGE_W-1:0] page);
		int       where;
		outcome_t o;
		where = -1;
		for (int i = 0; i < cpr_pkg::FRAMES_DEF; i++)
			if (where < 0 && in_use[i] && page_of[i] == page)
				where = i;
		if (where >= 0) begin
			recent[where] = 1;
			o.hit = 1'b1;
		end else begin
			// second chance: clear set bits until a clear one turns up
			while (recent[hand]) begin
				recent[hand] = 0;
				hand = (hand + 1) % cpr_pkg::FRAMES_DEF;
			end
			where = hand;
			hand = (hand + 1) % cpr_pkg::FRAMES_DEF;
			page_of[where] = page;
			in_use[where]  = 1;
			recent[where]  = 1;
			if (faults != cpr_pkg::FAULT_MAX)
				faults = faults + 1'b1;
			o.hit = 1'b0;
		end
		o.frame = where[cpr_pkg::INDEX_W-1:0];
		o.total = faults;
		due.push_back(o);
	endfunction

	function void check_result(logic h, logic [cpr_pkg::INDEX_W-1:0] f,
			logic [cpr_pkg::FAULT_W-1:0] t);
		outcome_t o;
		if (due.size() == 0) begin
			$error("result with no page pending: hit=%0b frame_index=%0d fault_total=%0d",
				h, f, t);
			errors++;
			return;
		end
		o = due.pop_front();
		if (h !== o.hit) begin
			$error("hit: expected %0b, got %0b", o.hit, h);
			errors++;
		end
		if (f !== o.frame) begin
			$error("frame_index: expected %0d, got %0d", o.frame, f);
			errors++;
		end
		if (t !== o.total) begin
			$error("fault_total: expected %0d, got %0d", o.total, t);
			errors++;
		end
	endfunction

	function int pending();
		return due.size();
	endfunction

endclass

module clock_page_replacement_test;

	// A correct run (1600+ items plus random gaps and two long output stalls)
	// ends far inside this limit; it allows several times that run's length.
	localparam int LIMIT      = 600000;
	localparam int HOLD_LEN   = 400;
	localparam int TAIL_WAIT  = 60;
	localparam int RAND_ITEMS = 1600;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [cpr_pkg::PAGE_W-1:0]   page_number;
	logic                         out_valid;
	logic                         out_ready;
	logic                         hit;
	logic [cpr_pkg::INDEX_W-1:0]  frame_index;
	logic [cpr_pkg::FAULT_W-1:0]  fault_total;

	page_ref_book book;
	int           cyc;
	bit           calm;     // both sides stop idling while set
	int           hold_left;

	clock_page_replacement u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.page_number (page_number),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.frame_index (frame_index),
		.fault_total (fault_total)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake or lost result ends here.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Outputs are sampled at the rising edge, pre-update values.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_result(hit, frame_index, fault_total);
	end

	// Receiver: random back-pressure, decided at the falling edge. Twice in
	// the run it holds off for a long stretch so the block fills and stalls
	// its input while the sender keeps offering items.
	initial begin
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (cyc == 3000 || cyc == 14000)
				hold_left = HOLD_LEN;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 19);
			end
		end
	end

	// Offer one page; returns once it has been accepted. Each falling edge
	// gets at most one assignment to in_valid.
	task automatic send_page(input logic [cpr_pkg::PAGE_W-1:0] p);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		page_number <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		book.note_page(p);
	endtask

	// Random phase: a small working set per block of items gives plenty of
	// hits and second-chance sweeps; a minority of full-range pages is noise.
	task automatic run_random(input int count);
		logic [cpr_pkg::PAGE_W-1:0] pool[8];
		int                         pool_n;
		logic [cpr_pkg::PAGE_W-1:0] p;
		pool_n = 5;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				pool_n = $urandom_range(8, 4);
				for (int k = 0; k < 8; k++)
					pool[k] = cpr_pkg::PAGE_W'($urandom_range(16'hFFFF));
			end
			// long stretch with no idling on either side
			calm = (n >= 600 && n < 900);
			if ($urandom_range(99) < 85)
				p = pool[$urandom_range(pool_n - 1)];
			else
				p = cpr_pkg::PAGE_W'($urandom_range(16'hFFFF));
			send_page(p);
		end
		calm = 1'b0;
	endtask

	initial begin
		logic [cpr_pkg::PAGE_W-1:0] directed[$];
		book        = new();
		cyc         = 0;
		calm        = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		page_number = '0;
		out_ready   = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: page zero into an empty table (must miss), all-ones page,
		// hits on both, fill the table, then a miss with every reference bit
		// set so the hand makes a full turn. Then mixed hits that leave some
		// bits clear, repeats of one page, and a few more extremes.
		directed = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h0002,
			16'h0003, 16'h8000, 16'h5555, 16'hAAAA, 16'h5555, 16'h8000,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001, 16'hAAAA, 16'hFFFE,
			16'h0000, 16'h8000, 16'h5555, 16'h00FF, 16'hFF00};
		foreach (directed[i])
			send_page(directed[i]);

		run_random(RAND_ITEMS);

		@(negedge clk);
		in_valid <= 1'b0;

		// Drain, then keep watching for any stray result before the verdict.
		while (book.pending() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		if (book.errors == 0 && book.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
